// File: rtl/tlec_pkg.sv
// shared types and constants of the two-level exclusive cache model
package tlec_pkg;

    localparam int ADDR_W = 48;
    localparam int TAG_W  = 48;

    // configuration register indexes (word address bits [4:2])
    localparam logic [2:0] REG_BLOCK_OFFSET = 3'd0;
    localparam logic [2:0] REG_L1_SET_BITS  = 3'd1;
    localparam logic [2:0] REG_L1_WAYS      = 3'd2;
    localparam logic [2:0] REG_L2_SET_BITS  = 3'd3;
    localparam logic [2:0] REG_L2_WAYS      = 3'd4;
    localparam logic [2:0] REG_USE_LRU      = 3'd5;

    // geometry limits of the configuration fields
    localparam logic [3:0] OFFSET_TOP = 4'd12;
    localparam int         L1_SET_TOP = 6;
    localparam int         L2_SET_TOP = 8;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] line_addr;
    } l1_entry_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } l2_entry_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINE,
        ST_TAG1,
        ST_TAG2,
        ST_L1_RD,
        ST_L1_CHK,
        ST_L1_DEC,
        ST_SH1_RD,
        ST_SH1_WR,
        ST_SH1_END,
        ST_L1_WR,
        ST_L2_RD,
        ST_L2_CHK,
        ST_L2_DEC,
        ST_SH2_RD,
        ST_SH2_WR,
        ST_SH2_END,
        ST_FILL,
        ST_VLINE,
        ST_VTAG,
        ST_L2_WR,
        ST_DONE
    } state_t;

endpackage

// File: rtl/tlec_ram.sv
// generic simple dual-port ram with registered read
module tlec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/two_level_exclusive_cache_model.sv
// top level of the two-level exclusive set-associative cache model
// Each word on the item channel is one read or write access at a 48-bit byte
// address; for each accepted word exactly one result word comes out, telling
// whether the access hit L1, hit L2 or went to memory, whether it was a write,
// and whether an L1 fill pushed the oldest L1 line into L2. Both levels keep
// each set in age order (slot 0 oldest). The line stores live in two rams
// (L1 tag plus line address, L2 tag, each with its valid bit), and a small
// sequencer walks them one way at a time with a single shared barrel shifter
// for set and tag extraction. An access splits the address into line, tags and
// sets, reads and checks each way searched, moves slots when a set is reordered
// and then closes the set, and ends with its decisions, ram writes and the
// result word. A new access word is accepted only once the sequencer is idle
// again. A result word still stalled on the output holds the sequencer in its
// last state until it is taken.
// After reset the block sweeps both rams to clear every valid bit, one entry
// per cycle over max(MAX_L1_SETS*MAX_L1_WAYS, MAX_L2_SETS*MAX_L2_WAYS) entries
// (4096 with default parameters); item_stall stays high during the sweep while
// the configuration port works as usual. The user must write configuration over
// the apb-style port only while the block is idle; the block does not enforce it.
module two_level_exclusive_cache_model #(
    parameter int MAX_L1_SETS  = 64,
    parameter int MAX_L1_WAYS  = 8,
    parameter int MAX_L2_SETS  = 256,
    parameter int MAX_L2_WAYS  = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // access channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [47:0] address,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        l1_hit,
    output logic        l2_hit,
    output logic        memory_read,
    output logic        memory_write,
    output logic        victim_to_l2
);

    // ram geometry
    localparam int D1 = MAX_L1_SETS * MAX_L1_WAYS;
    localparam int D2 = MAX_L2_SETS * MAX_L2_WAYS;
    localparam int A1 = D1 > 1 ? $clog2(D1) : 1;
    localparam int A2 = D2 > 1 ? $clog2(D2) : 1;
    localparam int DM = D1 > D2 ? D1 : D2;
    localparam int CW = $clog2(DM + 1);

    // largest usable set-bit counts and set index widths
    localparam int FL1   = $clog2(MAX_L1_SETS + 1) - 1;
    localparam int FL2   = $clog2(MAX_L2_SETS + 1) - 1;
    localparam int SMAX1 = FL1 < tlec_pkg::L1_SET_TOP ? FL1 : tlec_pkg::L1_SET_TOP;
    localparam int SMAX2 = FL2 < tlec_pkg::L2_SET_TOP ? FL2 : tlec_pkg::L2_SET_TOP;
    localparam int SW1   = SMAX1 > 0 ? SMAX1 : 1;
    localparam int SW2   = SMAX2 > 0 ? SMAX2 : 1;

    // way counter width, able to hold either level's way count
    localparam int WM = MAX_L1_WAYS > MAX_L2_WAYS ? MAX_L1_WAYS : MAX_L2_WAYS;
    localparam int WC = $clog2(WM + 1);

    // addresses narrower than the port are truncated
    localparam logic [47:0] ADDR_MASK = ADDRESS_BITS >= 48 ? {48{1'b1}} :
        48'((64'd1 << ADDRESS_BITS) - 64'd1);

    localparam int L1W = $bits(tlec_pkg::l1_entry_t);
    localparam int L2W = $bits(tlec_pkg::l2_entry_t);

    // configuration registers
    logic [3:0] cfg_off_reg;
    logic [2:0] cfg_s1_reg;
    logic [3:0] cfg_w1_reg;
    logic [3:0] cfg_s2_reg;
    logic [4:0] cfg_w2_reg;
    logic       cfg_lru_reg;

    logic       cfg_write;

    // sequencer state
    tlec_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    clr_reg, clr_next;
    logic             kind_reg, kind_next;
    logic [47:0]      addr_reg, addr_next;
    logic [3:0]       off_reg, off_next;
    logic [2:0]       s1_reg, s1_next;
    logic [3:0]       s2_reg, s2_next;
    logic [WC-1:0]    w1_reg, w1_next;
    logic [WC-1:0]    w2_reg, w2_next;
    logic             lru_reg, lru_next;
    logic [47:0]      line_reg, line_next;
    logic [47:0]      tag1_reg, tag1_next;
    logic [47:0]      tag2_reg, tag2_next;
    logic [SW1-1:0]   set1_reg, set1_next;
    logic [SW2-1:0]   set2_reg, set2_next;
    logic [WC-1:0]    way_reg, way_next;
    logic             hit1f_reg, hit1f_next;
    logic [WC-1:0]    hit1i_reg, hit1i_next;
    logic             free1f_reg, free1f_next;
    logic [WC-1:0]    free1i_reg, free1i_next;
    logic             hit2f_reg, hit2f_next;
    logic [WC-1:0]    hit2i_reg, hit2i_next;
    logic             free2f_reg, free2f_next;
    logic [WC-1:0]    free2i_reg, free2i_next;
    logic [WC-1:0]    slot_reg, slot_next;
    logic [47:0]      victim_reg, victim_next;
    logic             vic_reg, vic_next;
    logic             ins_reg, ins_next;
    logic             h1_reg, h1_next;
    logic             h2_reg, h2_next;
    logic             mr_reg, mr_next;

    // result word
    logic ov_reg, ov_next;
    logic o_l1_reg, o_l1_next;
    logic o_l2_reg, o_l2_next;
    logic o_mr_reg, o_mr_next;
    logic o_mw_reg, o_mw_next;
    logic o_vic_reg, o_vic_next;

    // ram ports
    logic                    ram1_we;
    logic [A1-1:0]           ram1_waddr, ram1_raddr;
    tlec_pkg::l1_entry_t     ram1_wdata, ram1_rdata;
    logic                    ram2_we;
    logic [A2-1:0]           ram2_waddr, ram2_raddr;
    tlec_pkg::l2_entry_t     ram2_wdata, ram2_rdata;

    // shared shifter
    logic [47:0] sh_src, sh_out;
    logic [3:0]  sh_amt;

    logic [SW1-1:0] mask1;
    logic [SW2-1:0] mask2;
    logic [WC-1:0]  way_inc;

    // effective geometry from the configuration registers
    logic [3:0]    g_off;
    logic [2:0]    g_s1;
    logic [3:0]    g_s2;
    logic [WC-1:0] g_w1;
    logic [WC-1:0] g_w2;

    tlec_ram #(.WIDTH(L1W), .DEPTH(D1)) u_l1_ram (
        .clk   (clk),
        .we    (ram1_we),
        .waddr (ram1_waddr),
        .wdata (ram1_wdata),
        .raddr (ram1_raddr),
        .rdata (ram1_rdata)
    );

    tlec_ram #(.WIDTH(L2W), .DEPTH(D2)) u_l2_ram (
        .clk   (clk),
        .we    (ram2_we),
        .waddr (ram2_waddr),
        .wdata (ram2_wdata),
        .raddr (ram2_raddr),
        .rdata (ram2_rdata)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_off_reg <= 4'd4;
            cfg_s1_reg  <= 3'd0;
            cfg_w1_reg  <= 4'd1;
            cfg_s2_reg  <= 4'd0;
            cfg_w2_reg  <= 5'd1;
            cfg_lru_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                tlec_pkg::REG_BLOCK_OFFSET: cfg_off_reg <= pwdata[3:0];
                tlec_pkg::REG_L1_SET_BITS:  cfg_s1_reg  <= pwdata[2:0];
                tlec_pkg::REG_L1_WAYS:      cfg_w1_reg  <= pwdata[3:0];
                tlec_pkg::REG_L2_SET_BITS:  cfg_s2_reg  <= pwdata[3:0];
                tlec_pkg::REG_L2_WAYS:      cfg_w2_reg  <= pwdata[4:0];
                tlec_pkg::REG_USE_LRU:      cfg_lru_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            tlec_pkg::REG_BLOCK_OFFSET: prdata = {28'd0, cfg_off_reg};
            tlec_pkg::REG_L1_SET_BITS:  prdata = {29'd0, cfg_s1_reg};
            tlec_pkg::REG_L1_WAYS:      prdata = {28'd0, cfg_w1_reg};
            tlec_pkg::REG_L2_SET_BITS:  prdata = {28'd0, cfg_s2_reg};
            tlec_pkg::REG_L2_WAYS:      prdata = {27'd0, cfg_w2_reg};
            tlec_pkg::REG_USE_LRU:      prdata = {31'd0, cfg_lru_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // clamp the geometry into the supported ranges
    always_comb
    begin
        g_off = (cfg_off_reg > tlec_pkg::OFFSET_TOP) ? tlec_pkg::OFFSET_TOP : cfg_off_reg;
        g_s1  = (int'(cfg_s1_reg) > SMAX1) ? 3'(SMAX1) : cfg_s1_reg;
        g_s2  = (int'(cfg_s2_reg) > SMAX2) ? 4'(SMAX2) : cfg_s2_reg;
        if (cfg_w1_reg == 4'd0)
            g_w1 = WC'(1);
        else if (int'(cfg_w1_reg) > MAX_L1_WAYS)
            g_w1 = WC'(MAX_L1_WAYS);
        else
            g_w1 = WC'(cfg_w1_reg);
        if (cfg_w2_reg == 5'd0)
            g_w2 = WC'(1);
        else if (int'(cfg_w2_reg) > MAX_L2_WAYS)
            g_w2 = WC'(MAX_L2_WAYS);
        else
            g_w2 = WC'(cfg_w2_reg);
    end

    assign sh_out  = sh_src >> sh_amt;
    assign mask1   = SW1'((32'd1 << s1_reg) - 32'd1);
    assign mask2   = SW2'((32'd1 << s2_reg) - 32'd1);
    assign way_inc = way_reg + WC'(1);

    assign item_stall   = (state_reg != tlec_pkg::ST_IDLE);
    assign result_valid = ov_reg;
    assign l1_hit       = o_l1_reg;
    assign l2_hit       = o_l2_reg;
    assign memory_read  = o_mr_reg;
    assign memory_write = o_mw_reg;
    assign victim_to_l2 = o_vic_reg;

    // sequencer: next state, ram control and datapath loads
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        kind_next   = kind_reg;
        addr_next   = addr_reg;
        off_next    = off_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        lru_next    = lru_reg;
        line_next   = line_reg;
        tag1_next   = tag1_reg;
        tag2_next   = tag2_reg;
        set1_next   = set1_reg;
        set2_next   = set2_reg;
        way_next    = way_reg;
        hit1f_next  = hit1f_reg;
        hit1i_next  = hit1i_reg;
        free1f_next = free1f_reg;
        free1i_next = free1i_reg;
        hit2f_next  = hit2f_reg;
        hit2i_next  = hit2i_reg;
        free2f_next = free2f_reg;
        free2i_next = free2i_reg;
        slot_next   = slot_reg;
        victim_next = victim_reg;
        vic_next    = vic_reg;
        ins_next    = ins_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        mr_next     = mr_reg;
        ov_next     = ov_reg;
        o_l1_next   = o_l1_reg;
        o_l2_next   = o_l2_reg;
        o_mr_next   = o_mr_reg;
        o_mw_next   = o_mw_reg;
        o_vic_next  = o_vic_reg;

        ram1_we    = 1'b0;
        ram1_waddr = A1'(int'(set1_reg) * MAX_L1_WAYS + int'(way_reg));
        ram1_wdata = '0;
        ram1_raddr = A1'(int'(set1_reg) * MAX_L1_WAYS + int'(way_reg));
        ram2_we    = 1'b0;
        ram2_waddr = A2'(int'(set2_reg) * MAX_L2_WAYS + int'(way_reg));
        ram2_wdata = '0;
        ram2_raddr = A2'(int'(set2_reg) * MAX_L2_WAYS + int'(way_reg));

        sh_src = addr_reg;
        sh_amt = off_reg;

        // result word taken
        if (ov_reg && !result_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            tlec_pkg::ST_CLEAR:
            begin
                // sweep both rams to clear the valid bits
                ram1_we    = (clr_reg < CW'(D1));
                ram1_waddr = A1'(clr_reg);
                ram2_we    = (clr_reg < CW'(D2));
                ram2_waddr = A2'(clr_reg);
                clr_next   = clr_reg + CW'(1);
                if (clr_reg == CW'(DM - 1))
                begin
                    state_next = tlec_pkg::ST_IDLE;
                end
            end

            tlec_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    kind_next  = kind;
                    addr_next  = address & ADDR_MASK;
                    off_next   = g_off;
                    s1_next    = g_s1;
                    s2_next    = g_s2;
                    w1_next    = g_w1;
                    w2_next    = g_w2;
                    lru_next   = cfg_lru_reg;
                    state_next = tlec_pkg::ST_LINE;
                end
            end

            tlec_pkg::ST_LINE:
            begin
                sh_src     = addr_reg;
                sh_amt     = off_reg;
                line_next  = sh_out;
                state_next = tlec_pkg::ST_TAG1;
            end

            tlec_pkg::ST_TAG1:
            begin
                sh_src     = line_reg;
                sh_amt     = {1'b0, s1_reg};
                tag1_next  = sh_out;
                set1_next  = line_reg[SW1-1:0] & mask1;
                set2_next  = line_reg[SW2-1:0] & mask2;
                state_next = tlec_pkg::ST_TAG2;
            end

            tlec_pkg::ST_TAG2:
            begin
                sh_src      = line_reg;
                sh_amt      = s2_reg;
                tag2_next   = sh_out;
                way_next    = '0;
                hit1f_next  = 1'b0;
                free1f_next = 1'b0;
                state_next  = tlec_pkg::ST_L1_RD;
            end

            tlec_pkg::ST_L1_RD:
            begin
                state_next = tlec_pkg::ST_L1_CHK;
            end

            tlec_pkg::ST_L1_CHK:
            begin
                if (ram1_rdata.valid && ram1_rdata.tag == tag1_reg && !hit1f_reg)
                begin
                    hit1f_next = 1'b1;
                    hit1i_next = way_reg;
                end
                if (!ram1_rdata.valid && !free1f_reg)
                begin
                    free1f_next = 1'b1;
                    free1i_next = way_reg;
                end
                if (way_reg == '0)
                begin
                    victim_next = ram1_rdata.line_addr;
                end
                if (way_inc == w1_reg)
                begin
                    state_next = tlec_pkg::ST_L1_DEC;
                end
                else
                begin
                    way_next   = way_inc;
                    state_next = tlec_pkg::ST_L1_RD;
                end
            end

            tlec_pkg::ST_L1_DEC:
            begin
                h1_next  = hit1f_reg;
                h2_next  = 1'b0;
                mr_next  = 1'b0;
                vic_next = 1'b0;
                if (hit1f_reg)
                begin
                    if (lru_reg)
                    begin
                        // slot of the refreshed line once the hit is taken out
                        if (free1f_reg && free1i_reg < hit1i_reg)
                            slot_next = free1i_reg;
                        else if (free1f_reg)
                            slot_next = free1i_reg - WC'(1);
                        else
                            slot_next = w1_reg - WC'(1);
                        way_next   = hit1i_reg;
                        state_next = tlec_pkg::ST_SH1_RD;
                    end
                    else
                    begin
                        state_next = tlec_pkg::ST_DONE;
                    end
                end
                else
                begin
                    way_next    = '0;
                    hit2f_next  = 1'b0;
                    free2f_next = 1'b0;
                    ins_next    = 1'b0;
                    state_next  = tlec_pkg::ST_L2_RD;
                end
            end

            tlec_pkg::ST_SH1_RD:
            begin
                ram1_raddr = A1'(int'(set1_reg) * MAX_L1_WAYS + int'(way_inc));
                if (way_inc < w1_reg)
                    state_next = tlec_pkg::ST_SH1_WR;
                else
                    state_next = tlec_pkg::ST_SH1_END;
            end

            tlec_pkg::ST_SH1_WR:
            begin
                ram1_we    = 1'b1;
                ram1_wdata = ram1_rdata;
                way_next   = way_inc;
                state_next = tlec_pkg::ST_SH1_RD;
            end

            tlec_pkg::ST_SH1_END:
            begin
                // newest slot left empty after the shift
                ram1_we    = 1'b1;
                ram1_waddr = A1'(int'(set1_reg) * MAX_L1_WAYS + int'(w1_reg) - 1);
                state_next = tlec_pkg::ST_L1_WR;
            end

            tlec_pkg::ST_L1_WR:
            begin
                ram1_we              = 1'b1;
                ram1_waddr           = A1'(int'(set1_reg) * MAX_L1_WAYS + int'(slot_reg));
                ram1_wdata.valid     = 1'b1;
                ram1_wdata.tag       = tag1_reg;
                ram1_wdata.line_addr = addr_reg;
                if (vic_reg)
                    state_next = tlec_pkg::ST_VLINE;
                else
                    state_next = tlec_pkg::ST_DONE;
            end

            tlec_pkg::ST_L2_RD:
            begin
                state_next = tlec_pkg::ST_L2_CHK;
            end

            tlec_pkg::ST_L2_CHK:
            begin
                if (ram2_rdata.valid && ram2_rdata.tag == tag2_reg && !hit2f_reg)
                begin
                    hit2f_next = 1'b1;
                    hit2i_next = way_reg;
                end
                if (!ram2_rdata.valid && !free2f_reg)
                begin
                    free2f_next = 1'b1;
                    free2i_next = way_reg;
                end
                if (way_inc == w2_reg)
                begin
                    state_next = tlec_pkg::ST_L2_DEC;
                end
                else
                begin
                    way_next   = way_inc;
                    state_next = tlec_pkg::ST_L2_RD;
                end
            end

            tlec_pkg::ST_L2_DEC:
            begin
                if (ins_reg)
                begin
                    // victim placement: first free slot, else drop the oldest
                    if (free2f_reg)
                    begin
                        slot_next  = free2i_reg;
                        state_next = tlec_pkg::ST_L2_WR;
                    end
                    else
                    begin
                        slot_next  = w2_reg - WC'(1);
                        way_next   = '0;
                        state_next = tlec_pkg::ST_SH2_RD;
                    end
                end
                else if (hit2f_reg)
                begin
                    // exclusive: the line leaves L2
                    h2_next    = 1'b1;
                    way_next   = hit2i_reg;
                    state_next = tlec_pkg::ST_SH2_RD;
                end
                else
                begin
                    mr_next    = 1'b1;
                    state_next = tlec_pkg::ST_FILL;
                end
            end

            tlec_pkg::ST_SH2_RD:
            begin
                ram2_raddr = A2'(int'(set2_reg) * MAX_L2_WAYS + int'(way_inc));
                if (way_inc < w2_reg)
                    state_next = tlec_pkg::ST_SH2_WR;
                else
                    state_next = tlec_pkg::ST_SH2_END;
            end

            tlec_pkg::ST_SH2_WR:
            begin
                ram2_we    = 1'b1;
                ram2_wdata = ram2_rdata;
                way_next   = way_inc;
                state_next = tlec_pkg::ST_SH2_RD;
            end

            tlec_pkg::ST_SH2_END:
            begin
                ram2_we    = 1'b1;
                ram2_waddr = A2'(int'(set2_reg) * MAX_L2_WAYS + int'(w2_reg) - 1);
                if (ins_reg)
                    state_next = tlec_pkg::ST_L2_WR;
                else
                    state_next = tlec_pkg::ST_FILL;
            end

            tlec_pkg::ST_FILL:
            begin
                if (free1f_reg)
                begin
                    slot_next  = free1i_reg;
                    vic_next   = 1'b0;
                    state_next = tlec_pkg::ST_L1_WR;
                end
                else
                begin
                    // full set: oldest line goes to L2, rest move down
                    slot_next  = w1_reg - WC'(1);
                    vic_next   = 1'b1;
                    way_next   = '0;
                    state_next = tlec_pkg::ST_SH1_RD;
                end
            end

            tlec_pkg::ST_VLINE:
            begin
                sh_src     = victim_reg;
                sh_amt     = off_reg;
                line_next  = sh_out;
                state_next = tlec_pkg::ST_VTAG;
            end

            tlec_pkg::ST_VTAG:
            begin
                sh_src      = line_reg;
                sh_amt      = s2_reg;
                tag2_next   = sh_out;
                set2_next   = line_reg[SW2-1:0] & mask2;
                way_next    = '0;
                hit2f_next  = 1'b0;
                free2f_next = 1'b0;
                ins_next    = 1'b1;
                state_next  = tlec_pkg::ST_L2_RD;
            end

            tlec_pkg::ST_L2_WR:
            begin
                ram2_we          = 1'b1;
                ram2_waddr       = A2'(int'(set2_reg) * MAX_L2_WAYS + int'(slot_reg));
                ram2_wdata.valid = 1'b1;
                ram2_wdata.tag   = tag2_reg;
                state_next       = tlec_pkg::ST_DONE;
            end

            tlec_pkg::ST_DONE:
            begin
                if (!ov_reg || !result_stall)
                begin
                    ov_next    = 1'b1;
                    o_l1_next  = h1_reg;
                    o_l2_next  = h2_reg;
                    o_mr_next  = mr_reg;
                    o_mw_next  = kind_reg;
                    o_vic_next = vic_reg;
                    state_next = tlec_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tlec_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlec_pkg::ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        addr_reg   <= addr_next;
        off_reg    <= off_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        w1_reg     <= w1_next;
        w2_reg     <= w2_next;
        lru_reg    <= lru_next;
        line_reg   <= line_next;
        tag1_reg   <= tag1_next;
        tag2_reg   <= tag2_next;
        set1_reg   <= set1_next;
        set2_reg   <= set2_next;
        way_reg    <= way_next;
        hit1f_reg  <= hit1f_next;
        hit1i_reg  <= hit1i_next;
        free1f_reg <= free1f_next;
        free1i_reg <= free1i_next;
        hit2f_reg  <= hit2f_next;
        hit2i_reg  <= hit2i_next;
        free2f_reg <= free2f_next;
        free2i_reg <= free2i_next;
        slot_reg   <= slot_next;
        victim_reg <= victim_next;
        vic_reg    <= vic_next;
        ins_reg    <= ins_next;
        h1_reg     <= h1_next;
        h2_reg     <= h2_next;
        mr_reg     <= mr_next;
        o_l1_reg   <= o_l1_next;
        o_l2_reg   <= o_l2_next;
        o_mr_reg   <= o_mr_next;
        o_mw_reg   <= o_mw_next;
        o_vic_reg  <= o_vic_next;
    end

`ifndef SYNTHESIS
    // each result names exactly one level that served the access
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot({l1_hit, l2_hit, memory_read}))
        else $error("result word does not name exactly one source");

    // an L1 hit never pushes a victim
    a_no_victim_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && victim_to_l2) |-> !l1_hit)
        else $error("victim reported on an L1 hit");

    // an accepted access starts the address split
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == tlec_pkg::ST_LINE))
        else $error("accepted access did not start the sequencer");

    // no access is taken during the clearing sweep
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlec_pkg::ST_CLEAR) |-> item_stall)
        else $error("access accepted during clearing sweep");
`endif

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the two-level exclusive cache model
`timescale 1ns / 1ps

module tb_top;

    localparam int L1_SETS_MAX = 64;
    localparam int L1_WAYS_MAX = 8;
    localparam int L2_SETS_MAX = 256;
    localparam int L2_WAYS_MAX = 16;

    typedef struct packed {
        logic        kind;
        logic [47:0] address;
    } access_t;

    typedef struct packed {
        logic l1_hit;
        logic l2_hit;
        logic memory_read;
        logic memory_write;
        logic victim_to_l2;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_stall;
    logic        kind;
    logic [47:0] address;
    logic        result_valid;
    logic        result_stall;
    logic        l1_hit;
    logic        l2_hit;
    logic        memory_read;
    logic        memory_write;
    logic        victim_to_l2;

    two_level_exclusive_cache_model u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .address      (address),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .l1_hit       (l1_hit),
        .l2_hit       (l2_hit),
        .memory_read  (memory_read),
        .memory_write (memory_write),
        .victim_to_l2 (victim_to_l2)
    );

    // shadow copy of the cache contents and registers
    logic [47:0] l1_tag_mem  [L1_SETS_MAX*L1_WAYS_MAX];
    logic [47:0] l1_addr_mem [L1_SETS_MAX*L1_WAYS_MAX];
    logic        l1_vld_mem  [L1_SETS_MAX*L1_WAYS_MAX];
    logic [47:0] l2_tag_mem  [L2_SETS_MAX*L2_WAYS_MAX];
    logic        l2_vld_mem  [L2_SETS_MAX*L2_WAYS_MAX];
    logic [3:0]  cfg_offset;
    logic [2:0]  cfg_l1_sets;
    logic [3:0]  cfg_l1_ways;
    logic [3:0]  cfg_l2_sets;
    logic [4:0]  cfg_l2_ways;
    logic        cfg_lru;
    int          cur_off, cur_s2, cur_w2;

    access_t  pending_words[$];
    outcome_t expected_outcomes[$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_off_cycles;
    int       hold_off_req;
    int       hold_off_seen;
    int       accepted_count;
    logic [47:0] recent_addr[$];

    // stall as seen at the last rising edge, so the driver knows what was taken
    logic item_stall_q;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int clamp_set_bits(int bits, int top, int max_sets);
        int s;
        s = (bits > top) ? top : bits;
        while (s > 0 && (1 << s) > max_sets)
            s--;
        return s;
    endfunction

    function automatic int clamp_ways(int ways, int max_ways);
        if (ways == 0)
            return 1;
        return (ways > max_ways) ? max_ways : ways;
    endfunction

    // drop one slot of an L1 set and close the gap toward the newest end
    task automatic l1_close_gap(int base, int from, int ways);
        for (int j = from; j + 1 < ways; j++)
        begin
            l1_tag_mem[base+j]  = l1_tag_mem[base+j+1];
            l1_addr_mem[base+j] = l1_addr_mem[base+j+1];
            l1_vld_mem[base+j]  = l1_vld_mem[base+j+1];
        end
        l1_vld_mem[base+ways-1] = 1'b0;
    endtask

    task automatic l2_close_gap(int base, int from, int ways);
        for (int j = from; j + 1 < ways; j++)
        begin
            l2_tag_mem[base+j] = l2_tag_mem[base+j+1];
            l2_vld_mem[base+j] = l2_vld_mem[base+j+1];
        end
        l2_vld_mem[base+ways-1] = 1'b0;
    endtask

    task automatic l1_free_slot(int base, int ways, output int slot);
        slot = -1;
        for (int i = 0; i < ways; i++)
            if (slot < 0 && !l1_vld_mem[base+i])
                slot = i;
    endtask

    // victim line enters L2 at the first free slot, evicting the oldest if full
    task automatic l2_take_victim(logic [47:0] line_addr);
        logic [47:0] set2;
        int base;
        int slot;
        set2 = (line_addr >> cur_off) & ((48'd1 << cur_s2) - 1);
        base = int'(set2) * L2_WAYS_MAX;
        slot = -1;
        for (int i = 0; i < cur_w2; i++)
            if (slot < 0 && !l2_vld_mem[base+i])
                slot = i;
        if (slot < 0)
        begin
            l2_close_gap(base, 0, cur_w2);
            slot = cur_w2 - 1;
        end
        l2_tag_mem[base+slot] = line_addr >> (cur_off + cur_s2);
        l2_vld_mem[base+slot] = 1'b1;
    endtask

    // predicted outcome of one access; updates the shadow cache
    task automatic predict_access(access_t acc, output outcome_t res);
        int s1, w1, base1, base2, hit_idx, slot;
        logic [47:0] set1, tag1, set2, tag2, victim;
        cur_off = (cfg_offset > tlec_pkg::OFFSET_TOP) ? 12 : int'(cfg_offset);
        s1      = clamp_set_bits(cfg_l1_sets, tlec_pkg::L1_SET_TOP, L1_SETS_MAX);
        cur_s2  = clamp_set_bits(cfg_l2_sets, tlec_pkg::L2_SET_TOP, L2_SETS_MAX);
        w1      = clamp_ways(cfg_l1_ways, L1_WAYS_MAX);
        cur_w2  = clamp_ways(cfg_l2_ways, L2_WAYS_MAX);
        set1 = (acc.address >> cur_off) & ((48'd1 << s1) - 1);
        tag1 = acc.address >> (cur_off + s1);
        set2 = (acc.address >> cur_off) & ((48'd1 << cur_s2) - 1);
        tag2 = acc.address >> (cur_off + cur_s2);
        base1 = int'(set1) * L1_WAYS_MAX;
        base2 = int'(set2) * L2_WAYS_MAX;
        res = '0;
        res.memory_write = acc.kind;
        hit_idx = -1;
        for (int i = 0; i < w1; i++)
            if (hit_idx < 0 && l1_vld_mem[base1+i] && l1_tag_mem[base1+i] == tag1)
                hit_idx = i;
        if (hit_idx >= 0)
        begin
            res.l1_hit = 1'b1;
            if (cfg_lru)
            begin
                l1_close_gap(base1, hit_idx, w1);
                l1_free_slot(base1, w1, slot);
                if (slot < 0)
                    slot = w1 - 1;
                l1_tag_mem[base1+slot]  = tag1;
                l1_addr_mem[base1+slot] = acc.address;
                l1_vld_mem[base1+slot]  = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < cur_w2; i++)
                if (hit_idx < 0 && l2_vld_mem[base2+i] && l2_tag_mem[base2+i] == tag2)
                    hit_idx = i;
            if (hit_idx >= 0)
            begin
                res.l2_hit = 1'b1;
                l2_close_gap(base2, hit_idx, cur_w2);
            end
            else
                res.memory_read = 1'b1;
            l1_free_slot(base1, w1, slot);
            if (slot < 0)
            begin
                victim = l1_addr_mem[base1];
                l1_close_gap(base1, 0, w1);
                slot = w1 - 1;
                res.victim_to_l2 = 1'b1;
            end
            l1_tag_mem[base1+slot]  = tag1;
            l1_addr_mem[base1+slot] = acc.address;
            l1_vld_mem[base1+slot]  = 1'b1;
            if (res.victim_to_l2)
                l2_take_victim(victim);
        end
    endtask

    // apb write: setup then access phase, changes on the falling edge
    task automatic write_register(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (index)
            tlec_pkg::REG_BLOCK_OFFSET: cfg_offset  = value[3:0];
            tlec_pkg::REG_L1_SET_BITS:  cfg_l1_sets = value[2:0];
            tlec_pkg::REG_L1_WAYS:      cfg_l1_ways = value[3:0];
            tlec_pkg::REG_L2_SET_BITS:  cfg_l2_sets = value[3:0];
            tlec_pkg::REG_L2_WAYS:      cfg_l2_ways = value[4:0];
            tlec_pkg::REG_USE_LRU:      cfg_lru     = value[0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_geometry(int off, int s1, int w1, int s2, int w2, int lru);
        write_register(tlec_pkg::REG_BLOCK_OFFSET, off);
        write_register(tlec_pkg::REG_L1_SET_BITS, s1);
        write_register(tlec_pkg::REG_L1_WAYS, w1);
        write_register(tlec_pkg::REG_L2_SET_BITS, s2);
        write_register(tlec_pkg::REG_L2_WAYS, w2);
        write_register(tlec_pkg::REG_USE_LRU, lru);
    endtask

    // queue a word and its predicted outcome; the predictor runs in send order
    task automatic queue_access(logic k, logic [47:0] a);
        access_t  acc;
        outcome_t res;
        acc.kind = k;
        acc.address = a;
        pending_words.push_back(acc);
        predict_access(acc, res);
        expected_outcomes.push_back(res);
        recent_addr.push_back(a);
        if (recent_addr.size() > 24)
            void'(recent_addr.pop_front());
    endtask

    // wait for every queued word to be sent and every outcome to come back
    task automatic drain_all();
        while (pending_words.size() != 0 || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // random accesses: mostly reuse of a small working set so hits happen
    task automatic random_phase(int count, int line_span);
        logic [47:0] a;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0: a = 48'({$urandom, $urandom});
                1, 2, 3:
                    if (recent_addr.size() != 0)
                        a = recent_addr[$urandom_range(0, recent_addr.size()-1)];
                    else
                        a = 48'($urandom);
                default: a = 48'($urandom_range(0, line_span) << $urandom_range(0, 12)
                                 | $urandom_range(0, 15));
            endcase
            queue_access($urandom_range(0, 1), a);
        end
    endtask

    // driver: offers the head of the queue, holds the word while stalled
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall_q)
                void'(pending_words.pop_front());
            if (pending_words.size() != 0 &&
                ((item_valid && item_stall_q) || $urandom_range(1, 100) > send_idle_pct))
            begin
                item_valid <= 1'b1;
                kind       <= pending_words[0].kind;
                address    <= pending_words[0].address;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_stall_q <= 1'b1;
        else
            item_stall_q <= item_stall | ~item_valid;
    end

    // receiver stall: random, or a long hold-off counted down here
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall    <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_seen   <= 0;
        end
        else if (hold_off_seen != hold_off_req)
        begin
            result_stall    <= 1'b1;
            hold_off_seen   <= hold_off_req;
            hold_off_cycles <= 2000;
        end
        else if (hold_off_cycles > 0)
        begin
            result_stall    <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            result_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
    end

    // monitor: compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t exp_o;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {l1_hit, l2_hit, memory_read, memory_write, victim_to_l2};
            if (expected_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %b", got);
            end
            else
            begin
                exp_o = expected_outcomes.pop_front();
                if (got !== exp_o)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected hit1/hit2/mrd/mwr/vict %b got %b",
                                 exp_o, got);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        kind = 1'b0;
        address = '0;
        item_valid = 1'b0;
        result_stall = 1'b0;
        mismatch_count = 0;
        hold_off_req = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_offset = 4;
        cfg_l1_sets = 0;
        cfg_l1_ways = 1;
        cfg_l2_sets = 0;
        cfg_l2_ways = 1;
        cfg_lru = 1'b0;
        foreach (l1_vld_mem[i])
            l1_vld_mem[i] = 1'b0;
        foreach (l2_vld_mem[i])
            l2_vld_mem[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset geometry, tag zero, address extremes, direct-map evictions
        queue_access(1'b0, 48'h0);
        queue_access(1'b1, 48'h0);
        queue_access(1'b0, 48'hFFFF_FFFF_FFFF);
        queue_access(1'b1, 48'h0);
        queue_access(1'b0, 48'hFFFF_FFFF_FFFF);
        queue_access(1'b0, 48'h5555_5555_5555);
        queue_access(1'b1, 48'hAAAA_AAAA_AAAA);
        drain_all();

        // directed: 2-way L1 LRU, small L2, hit refresh and victim chain
        set_geometry(4, 1, 2, 1, 2, 1);
        queue_access(1'b0, 48'h000);
        queue_access(1'b0, 48'h020);
        queue_access(1'b0, 48'h000);
        queue_access(1'b0, 48'h040);
        queue_access(1'b0, 48'h060);
        queue_access(1'b1, 48'h020);
        queue_access(1'b0, 48'h000);
        queue_access(1'b0, 48'h080);
        queue_access(1'b0, 48'h0A0);
        queue_access(1'b0, 48'h040);
        drain_all();

        // out-of-range register values clamp; zero ways act as one
        set_geometry(15, 7, 0, 15, 0, 0);
        queue_access(1'b0, 48'h1000);
        queue_access(1'b0, 48'h2000);
        queue_access(1'b0, 48'h1000);
        drain_all();
        set_geometry(0, 6, 15, 8, 31, 1);
        queue_access(1'b0, 48'h0);
        queue_access(1'b1, 48'h1);
        queue_access(1'b0, 48'h0);
        drain_all();

        // random phases through idling profiles and geometries (extremes included)
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            case (ph)
                0: set_geometry(4, 0, 1, 0, 1, 0);
                1: set_geometry(12, 6, 8, 8, 16, 1);
                2: set_geometry(0, 0, 8, 0, 16, 0);
                3: set_geometry($urandom_range(0, 12), $urandom_range(0, 2),
                                $urandom_range(1, 4), $urandom_range(0, 3),
                                $urandom_range(1, 6), 1);
                default: set_geometry($urandom_range(0, 15), $urandom_range(0, 7),
                                      $urandom_range(0, 15), $urandom_range(0, 15),
                                      $urandom_range(0, 31), $urandom_range(0, 1));
            endcase
            if (ph == 2)
                hold_off_req++;
            random_phase(70, (ph == 1) ? 4095 : 40);
            drain_all();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
